FILE: hdl/urm_pkg.sv
// shared constants, types and conversion constants of the ultrasonic range measurer
package urm_pkg;

  localparam int ECHO_COUNT_BITS = 16;
  localparam int CM_BITS         = 11;
  localparam int PERIOD_BITS     = 20;
  localparam int TRIG_BITS       = 10;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 20;

  // cm per us of echo is 17/1000 (speed of sound, round trip halved)
  localparam int SOUND_NUM   = 17;
  localparam int SOUND_DEN   = 1000;
  localparam int PROD_BITS   = ECHO_COUNT_BITS + 5;
  localparam int RECIP_SHIFT = PROD_BITS + 10;
  localparam int RECIP_BITS  = RECIP_SHIFT - 9;
  localparam int RAW_BITS    = PROD_BITS - 9;
  localparam int CALC_BITS   = (RAW_BITS > CM_BITS) ? RAW_BITS : CM_BITS;
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(SOUND_DEN) - 64'd1) / 64'(SOUND_DEN));

  localparam logic [TRIG_BITS-1:0]   RST_TRIG_WIDTH  = TRIG_BITS'(10);
  localparam logic [PERIOD_BITS-1:0] RST_PERIOD      = PERIOD_BITS'(75000);
  localparam logic [CM_BITS-1:0]     RST_OFFSET      = CM_BITS'(39);
  localparam logic [CM_BITS-1:0]     RST_MIN         = CM_BITS'(2);
  localparam logic [CM_BITS-1:0]     RST_MAX         = CM_BITS'(400);
  localparam logic [CM_BITS-1:0]     RST_STOP_THRESH = CM_BITS'(10);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TRIG_WIDTH  = 3'd0,
    REG_PERIOD      = 3'd1,
    REG_OFFSET      = 3'd2,
    REG_MIN         = 3'd3,
    REG_MAX         = 3'd4,
    REG_STOP_THRESH = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [CM_BITS-1:0] offset_cm;
    logic [CM_BITS-1:0] min_cm;
    logic [CM_BITS-1:0] max_cm;
  } cal_t;

endpackage

FILE: hdl/urm_dist.sv
// echo width to clamped distance in centimetres
module urm_dist import urm_pkg::*; (
  input  logic [ECHO_COUNT_BITS-1:0] width_i,
  input  cal_t                       cal_i,
  output logic [CM_BITS-1:0]         distance_cm_o
);

  logic [PROD_BITS-1:0]            prod;
  logic [PROD_BITS+RECIP_BITS-1:0] scaled;
  logic [RAW_BITS-1:0]             raw;
  logic [CALC_BITS-1:0]            raw_x;
  logic [CALC_BITS-1:0]            off_x;
  logic [CALC_BITS-1:0]            min_x;
  logic [CALC_BITS-1:0]            max_x;
  logic [CALC_BITS-1:0]            diff;

  // floor(width * 17 / 1000) via reciprocal multiply, exact over the width range
  assign prod   = PROD_BITS'(width_i) * PROD_BITS'(SOUND_NUM);
  assign scaled = (PROD_BITS+RECIP_BITS)'(prod) * (PROD_BITS+RECIP_BITS)'(RECIP);
  assign raw    = scaled[RECIP_SHIFT +: RAW_BITS];

  assign raw_x = CALC_BITS'(raw);
  assign off_x = CALC_BITS'(cal_i.offset_cm);
  assign min_x = CALC_BITS'(cal_i.min_cm);
  assign max_x = CALC_BITS'(cal_i.max_cm);
  assign diff  = raw_x - off_x;

  always_comb begin
    if (raw_x < off_x) begin
      distance_cm_o = cal_i.min_cm;
    end else if (diff > max_x) begin
      distance_cm_o = cal_i.max_cm;
    end else if (diff < min_x) begin
      distance_cm_o = cal_i.min_cm;
    end else begin
      distance_cm_o = CM_BITS'(diff);
    end
  end

endmodule

FILE: hdl/ultrasonic_range_measurer.sv
// top level of the ultrasonic range measurer
// One transaction is one microsecond tick with the sampled echo level; each one gives
// exactly one result transaction in the next cycle, and a new tick is taken every clock
// as long as the result register is empty or being emptied. The
// whole tick update (period and trigger counters, echo edge detect, saturating width
// counter, distance conversion by reciprocal multiply) is one level of logic between
// the state registers and the result register. The distance output is converted from
// the captured width held in state and the current calibration registers.
module ultrasonic_range_measurer import urm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     echo_level_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     trigger_level_o,
  output logic                     distance_valid_o,
  output logic [CM_BITS-1:0]       distance_cm_o,
  output logic                     too_close_o
);

  logic [TRIG_BITS-1:0]       trig_width_q;
  logic [PERIOD_BITS-1:0]     period_q;
  cal_t                       cal_q;
  logic [CM_BITS-1:0]         stop_thresh_q;

  logic                       echo_prev_q, echo_prev_d;
  logic                       measuring_q, measuring_d;
  logic [ECHO_COUNT_BITS-1:0] echo_cnt_q, echo_cnt_d;
  logic [ECHO_COUNT_BITS-1:0] width_q, width_d;
  logic [PERIOD_BITS-1:0]     period_cnt_q, period_cnt_d;
  logic [TRIG_BITS-1:0]       trig_cnt_q, trig_cnt_d;
  logic                       close_q, close_d;
  logic                       out_valid_q, out_valid_d;
  logic                       trig_out_q, trig_out_d;
  logic                       dvalid_q, dvalid_d;

  logic                       in_accept;
  logic                       cycle_start;
  logic [TRIG_BITS-1:0]       trig_eff;
  logic [PERIOD_BITS:0]       period_next;
  logic [CM_BITS-1:0]         dist_cm;

  urm_dist u_dist (
    .width_i       (width_q),
    .cal_i         (cal_q),
    .distance_cm_o (dist_cm)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  // tick update
  always_comb begin
    cycle_start  = (period_cnt_q == '0);
    close_d      = close_q;
    trig_eff     = trig_cnt_q;
    if (cycle_start) begin
      close_d  = (dist_cm < stop_thresh_q);
      trig_eff = trig_width_q;
    end
    trig_out_d = (trig_eff != '0);
    trig_cnt_d = trig_out_d ? (trig_eff - TRIG_BITS'(1)) : trig_eff;

    echo_cnt_d  = echo_cnt_q;
    measuring_d = measuring_q;
    width_d     = width_q;
    dvalid_d    = 1'b0;
    if (echo_level_i && !echo_prev_q) begin
      echo_cnt_d  = '0;
      measuring_d = 1'b1;
    end else if (measuring_q) begin
      if (!(&echo_cnt_q)) begin
        echo_cnt_d = echo_cnt_q + ECHO_COUNT_BITS'(1);
      end
      if (!echo_level_i && echo_prev_q) begin
        width_d     = echo_cnt_d;
        measuring_d = 1'b0;
        dvalid_d    = 1'b1;
      end
    end
    echo_prev_d = echo_level_i;

    period_next = {1'b0, period_cnt_q} + (PERIOD_BITS+1)'(1);
    if (period_next >= {1'b0, period_q}) begin
      period_cnt_d = '0;
    end else begin
      period_cnt_d = period_next[PERIOD_BITS-1:0];
    end

    out_valid_d = in_accept || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_width_q  <= RST_TRIG_WIDTH;
      period_q      <= RST_PERIOD;
      cal_q         <= '{offset_cm: RST_OFFSET, min_cm: RST_MIN, max_cm: RST_MAX};
      stop_thresh_q <= RST_STOP_THRESH;
      echo_prev_q   <= 1'b0;
      measuring_q   <= 1'b0;
      echo_cnt_q    <= '0;
      width_q       <= '0;
      period_cnt_q  <= '0;
      trig_cnt_q    <= '0;
      close_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      trig_out_q    <= 1'b0;
      dvalid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_TRIG_WIDTH:  trig_width_q     <= cfg_data_i[TRIG_BITS-1:0];
          REG_PERIOD:      period_q         <= cfg_data_i[PERIOD_BITS-1:0];
          REG_OFFSET:      cal_q.offset_cm  <= cfg_data_i[CM_BITS-1:0];
          REG_MIN:         cal_q.min_cm     <= cfg_data_i[CM_BITS-1:0];
          REG_MAX:         cal_q.max_cm     <= cfg_data_i[CM_BITS-1:0];
          REG_STOP_THRESH: stop_thresh_q    <= cfg_data_i[CM_BITS-1:0];
          default: ;
        endcase
      end
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        echo_prev_q  <= echo_prev_d;
        measuring_q  <= measuring_d;
        echo_cnt_q   <= echo_cnt_d;
        width_q      <= width_d;
        period_cnt_q <= period_cnt_d;
        trig_cnt_q   <= trig_cnt_d;
        close_q      <= close_d;
        trig_out_q   <= trig_out_d;
        dvalid_q     <= dvalid_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign trigger_level_o  = trig_out_q;
  assign distance_valid_o = dvalid_q;
  assign distance_cm_o    = dist_cm;
  assign too_close_o      = close_q;

`ifndef SYNTHESIS
  a_dist_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dist_cm <= cal_q.max_cm) || (dist_cm == cal_q.min_cm))
    else $error("distance outside clamp range");

  a_capture_ends_measure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && distance_valid_o) |-> (!measuring_q && !echo_prev_q))
    else $error("capture without end of measurement");

  a_start_trigger: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && period_cnt_q == '0) |=> (trigger_level_o == ($past(trig_width_q) != '0)))
    else $error("trigger pulse not launched at cycle start");

  a_rise_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && echo_level_i && !echo_prev_q) |=> (measuring_q && echo_cnt_q == '0))
    else $error("rising echo edge did not restart width count");
`endif

endmodule
